// File: hdl/positional_insert_remove_array_assert.svh
// Assertion macros for the positional insert/remove array.
`ifndef POSITIONAL_INSERT_REMOVE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_REMOVE_ARRAY_ASSERT_SVH
`ifndef SYNTHESIS
`define PIR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define PIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PIR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/pir_pkg.sv
// Shared types, codes and widths for the positional insert/remove array.
package pir_pkg;

    localparam int CAPACITY_DEF   = 8;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 4;
    localparam int WDATA_W = 32;
    localparam int STAT_W  = 2;
    localparam int RDATA_W = 32;
    localparam int COUNT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_OOB   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // evaluate and apply the captured command
    } dp_cmd_t;

endpackage

// File: hdl/pir_ctrl.sv
// Controller: accept, execute and deliver sequencing for one item at a time.
module pir_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pir_pkg::dp_cmd_t  dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    assign in_stall    = in_stall_reg;
    assign out_valid   = out_valid_reg;
    assign dp_cmd.load = in_valid && !in_stall_reg;
    assign dp_cmd.exec = (state_reg == S_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_stall_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b0;
                    in_stall_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: hdl/pir_dp.sv
// Datapath: command registers, element cells, fill count and result registers.
`include "positional_insert_remove_array_assert.svh"

module pir_dp
#(
    parameter int CAPACITY   = pir_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pir_pkg::DATA_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pir_pkg::dp_cmd_t               dp_cmd,
    input  logic [pir_pkg::CMD_W-1:0]      cmd,
    input  logic [pir_pkg::POS_W-1:0]      pos,
    input  logic [pir_pkg::WDATA_W-1:0]    write_data,
    input  logic                           append,
    input  logic                           has_data,
    output logic [pir_pkg::STAT_W-1:0]     status,
    output logic [pir_pkg::RDATA_W-1:0]    read_data,
    output logic [pir_pkg::COUNT_W-1:0]    count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > pir_pkg::POS_W) ? CNT_W : pir_pkg::POS_W;

    pir_pkg::cmd_t           cmd_reg;
    logic [CMP_W-1:0]        pos_reg;
    logic [DATA_WIDTH-1:0]   wdata_reg;
    logic                    app_reg;
    logic                    has_reg;
    logic [DATA_WIDTH-1:0]   cell_reg [CAPACITY];
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    pir_pkg::status_t        status_reg;
    logic [pir_pkg::RDATA_W-1:0] rdata_reg;

    pir_pkg::status_t        status_next;
    logic                    ok;
    logic [CMP_W-1:0]        cnt_x;
    logic [CMP_W-1:0]        ins_pos;
    logic [63:0]             wd_wide;
    logic [63:0]             rd_wide;
    logic [DATA_WIDTH-1:0]   up_src [CAPACITY];
    logic [DATA_WIDTH-1:0]   dn_src [CAPACITY];

    assign status    = status_reg;
    assign read_data = rdata_reg;
    assign count     = pir_pkg::COUNT_W'(cnt_reg);

    assign cnt_x   = CMP_W'(cnt_reg);
    assign ins_pos = app_reg ? cnt_x : pos_reg;
    assign wd_wide = 64'(write_data);
    assign rd_wide = 64'(cell_reg[pos_reg[IDX_W-1:0]]);

    // neighbor taps for shifting up and down
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_tap
        if (g > 0)
        begin : g_up
            assign up_src[g] = cell_reg[g-1];
        end
        else
        begin : g_up0
            assign up_src[g] = cell_reg[g];
        end
        if (g < CAPACITY - 1)
        begin : g_dn
            assign dn_src[g] = cell_reg[g+1];
        end
        else
        begin : g_dntop
            assign dn_src[g] = cell_reg[g];
        end
    end

    // checks per command: full before out of bounds for insert, empty before out of bounds for remove and read
    always_comb
    begin
        status_next = pir_pkg::ST_OK;
        case (cmd_reg)
            pir_pkg::CMD_WRITE:
            begin
                if (pos_reg >= cnt_x)
                    status_next = pir_pkg::ST_OOB;
            end
            pir_pkg::CMD_INSERT:
            begin
                if (cnt_x >= CMP_W'(CAPACITY))
                    status_next = pir_pkg::ST_FULL;
                else if (pos_reg > cnt_x)
                    status_next = pir_pkg::ST_OOB;
            end
            pir_pkg::CMD_REMOVE, pir_pkg::CMD_READ:
            begin
                if (cnt_reg == '0)
                    status_next = pir_pkg::ST_EMPTY;
                else if (pos_reg >= cnt_x)
                    status_next = pir_pkg::ST_OOB;
            end
            default:
            begin
                status_next = pir_pkg::ST_OK;
            end
        endcase
    end

    assign ok = (status_next == pir_pkg::ST_OK);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ok && cmd_reg == pir_pkg::CMD_INSERT)
            cnt_next = cnt_reg + 1'b1;
        else if (ok && cmd_reg == pir_pkg::CMD_REMOVE)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= pir_pkg::cmd_t'(cmd);
            pos_reg   <= CMP_W'(pos);
            wdata_reg <= wd_wide[DATA_WIDTH-1:0];
            app_reg   <= append;
            has_reg   <= has_data;
        end
        if (dp_cmd.exec)
        begin
            status_reg <= status_next;
            if (ok && cmd_reg == pir_pkg::CMD_READ)
                rdata_reg <= rd_wide[pir_pkg::RDATA_W-1:0];
            else
                rdata_reg <= '0;
        end
    end

    // each cell decides locally from its index
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec && ok)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                case (cmd_reg)
                    pir_pkg::CMD_WRITE:
                    begin
                        if (pos_reg == CMP_W'(i))
                            cell_reg[i] <= wdata_reg;
                    end
                    pir_pkg::CMD_INSERT:
                    begin
                        if (CMP_W'(i) > ins_pos && CMP_W'(i) <= cnt_x)
                            cell_reg[i] <= up_src[i];
                        else if (CMP_W'(i) == ins_pos && has_reg)
                            cell_reg[i] <= wdata_reg;
                    end
                    pir_pkg::CMD_REMOVE:
                    begin
                        if (CMP_W'(i) >= pos_reg && CMP_W'(i) < cnt_x - 1'b1)
                            cell_reg[i] <= dn_src[i];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (dp_cmd.exec)
            cnt_reg <= cnt_next;
    end

    `PIR_ASSERT_NEXT(a_fail_holds_count, clk, rst_n, dp_cmd.exec && !ok, cnt_reg == $past(cnt_reg))
    `PIR_ASSERT_NEXT(a_insert_grows, clk, rst_n, dp_cmd.exec && ok && cmd_reg == pir_pkg::CMD_INSERT, cnt_reg == $past(cnt_reg) + 1'b1)
    `PIR_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, dp_cmd.exec && ok && cmd_reg == pir_pkg::CMD_REMOVE, cnt_reg == $past(cnt_reg) - 1'b1)
    `PIR_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, CMP_W'(cnt_reg) <= CMP_W'(CAPACITY))

endmodule

// File: hdl/positional_insert_remove_array.sv
// Top level of the positional insert/remove array.
// Ordered store of up to CAPACITY elements; each item carries one command
// (write, insert or append, remove, read at a position) and yields one result
// with status, read element and the length after the command. One item is in
// flight at a time: an accepted item moves from the idle state, where it is
// accepted, through the execute state to the deliver state, where out_valid is
// high; the result leaves at an edge with out_stall low, and the next item is
// taken the cycle after the result leaves. in_stall rises once an item is
// accepted and stays high through execute and deliver, also under out_stall.
// The sequence is set by the controller's accept/execute/deliver states; the
// cells themselves shift in the execute state. Cell contents are not
// reset, only the fill count.
module positional_insert_remove_array
#(
    parameter int CAPACITY   = pir_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pir_pkg::DATA_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pir_pkg::CMD_W-1:0]      cmd,
    input  logic [pir_pkg::POS_W-1:0]      pos,
    input  logic [pir_pkg::WDATA_W-1:0]    write_data,
    input  logic                           append,
    input  logic                           has_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pir_pkg::STAT_W-1:0]     status,
    output logic [pir_pkg::RDATA_W-1:0]    read_data,
    output logic [pir_pkg::COUNT_W-1:0]    count
);

    pir_pkg::dp_cmd_t dp_cmd;

    pir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    pir_dp
    #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .cmd        (cmd),
        .pos        (pos),
        .write_data (write_data),
        .append     (append),
        .has_data   (has_data),
        .status     (status),
        .read_data  (read_data),
        .count      (count)
    );

endmodule
